FILE: design/i2c_master_write_with_trace_macros.svh
// ----------------------------------------------------------------------------
// I2C master write engine: assertion macros
// Shared helpers for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_WITH_TRACE_MACROS_SVH
`define I2C_MASTER_WRITE_WITH_TRACE_MACROS_SVH

// Same-cycle implication, sampled on clock and quiet during reset.
`define I2CMW_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and quiet during reset.
`define I2CMW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/i2cmw_pkg.sv
// ----------------------------------------------------------------------------
// I2C master write engine package
// Types, codes and sizes shared by the byte sequencer, the top level and the
// testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cmw_pkg;

   localparam int TRACE_DEPTH = 256;
   localparam int TRACE_AW    = $clog2(TRACE_DEPTH);
   localparam int TRACE_W     = 6;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_WRITE  = 2'd2;

   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_WRITE  = 2'd2;

   localparam logic [1:0] RES_BUS     = 2'd0;
   localparam logic [1:0] RES_TRACE   = 2'd1;
   localparam logic [1:0] RES_REJECT  = 2'd2;

   localparam logic [TRACE_W-1:0] TRC_NONE = 6'd0;
   localparam logic [TRACE_W-1:0] TRC_SCL  = 6'd1;
   localparam logic [TRACE_W-1:0] TRC_SDA  = 6'd2;
   localparam logic [TRACE_W-1:0] TRC_BOTH = 6'd3;

   localparam logic [2:0] BIT_LAST = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } top_state_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_START0,
      SEQ_START1,
      SEQ_BIT_A,
      SEQ_BIT_B,
      SEQ_BIT_C,
      SEQ_ACK0,
      SEQ_ACK1,
      SEQ_ACK2,
      SEQ_STOP0,
      SEQ_STOP1,
      SEQ_STOP2,
      SEQ_STOP3
   } seq_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       stop;
      logic       ack;
   } seq_start_type;

   typedef struct packed {
      logic               scl;
      logic               sda;
      logic               sda_drv;
      logic               bus;
      logic               nack;
      logic               last;
      logic               push;
      logic [TRACE_W-1:0] code;
   } seq_event_type;

   typedef struct packed {
      logic [1:0]         result_type;
      logic               scl_level;
      logic               sda_level;
      logic               sda_driven;
      logic               bus_driven;
      logic [TRACE_W-1:0] trace_value;
      logic               trace_valid;
      logic               nack_seen;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/i2cmw_trace_ram.sv
// ----------------------------------------------------------------------------
// I2C master write engine: trace memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmw_trace_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/i2cmw_seq.sv
// ----------------------------------------------------------------------------
// I2C master write engine: byte sequencer
// Steps through an optional start, eight data bits, the acknowledge slot and
// an optional stop, presenting one bus event and its trace code per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmw_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire i2cmw_pkg::seq_start_type start_info,
   input  wire logic                    advance,
   output i2cmw_pkg::seq_event_type     event_out
);

   import i2cmw_pkg::*;

   seq_phase_type phase_ff, phase_in;
   logic [2:0]    bit_cnt_ff, bit_cnt_in;
   logic [7:0]    shift_ff, shift_in;
   logic          ack_ff, ack_in;
   logic          stop_ff, stop_in;
   logic          cur_bit;

   assign cur_bit = shift_ff[7];

   always_comb begin
      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      ack_in     = ack_ff;
      stop_in    = stop_ff;
      if (start) begin
         phase_in   = start_info.first ? SEQ_START0 : SEQ_BIT_A;
         bit_cnt_in = '0;
         shift_in   = start_info.data;
         ack_in     = start_info.ack;
         stop_in    = start_info.stop;
      end else if (advance) begin
         case (phase_ff)
            SEQ_START0: phase_in = SEQ_START1;
            SEQ_START1: phase_in = SEQ_BIT_A;
            SEQ_BIT_A:  phase_in = SEQ_BIT_B;
            SEQ_BIT_B:  phase_in = SEQ_BIT_C;
            SEQ_BIT_C: begin
               shift_in   = {shift_ff[6:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + 3'd1;
               phase_in   = (bit_cnt_ff == BIT_LAST) ? SEQ_ACK0 : SEQ_BIT_A;
            end
            SEQ_ACK0:   phase_in = SEQ_ACK1;
            SEQ_ACK1:   phase_in = SEQ_ACK2;
            SEQ_ACK2:   phase_in = stop_ff ? SEQ_STOP0 : SEQ_IDLE;
            SEQ_STOP0:  phase_in = SEQ_STOP1;
            SEQ_STOP1:  phase_in = SEQ_STOP2;
            SEQ_STOP2:  phase_in = SEQ_STOP3;
            SEQ_STOP3:  phase_in = SEQ_IDLE;
            default:    phase_in = SEQ_IDLE;
         endcase
      end
   end

   always_comb begin
      event_out = '0;
      case (phase_ff)
         SEQ_START0: begin
            event_out = '{scl: 1'b1, sda: 1'b0, sda_drv: 1'b1, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b1, code: TRC_SCL};
         end
         SEQ_START1: begin
            event_out = '{scl: 1'b0, sda: 1'b0, sda_drv: 1'b1, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b1, code: TRC_NONE};
         end
         SEQ_BIT_A: begin
            event_out = '{scl: 1'b0, sda: cur_bit, sda_drv: 1'b1, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b1,
                          code: cur_bit ? TRC_BOTH : TRC_SCL};
         end
         SEQ_BIT_B: begin
            event_out = '{scl: 1'b1, sda: cur_bit, sda_drv: 1'b1, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b0, code: TRC_NONE};
         end
         SEQ_BIT_C: begin
            event_out = '{scl: 1'b0, sda: cur_bit, sda_drv: 1'b1, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b1, code: TRC_NONE};
         end
         SEQ_ACK0: begin
            event_out = '{scl: 1'b0, sda: 1'b1, sda_drv: 1'b0, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b1, code: TRC_SDA};
         end
         SEQ_ACK1: begin
            event_out = '{scl: 1'b1, sda: 1'b1, sda_drv: 1'b0, bus: 1'b1,
                          nack: 1'b0, last: 1'b0, push: 1'b1,
                          code: {4'd0, ack_ff, 1'b1}};
         end
         SEQ_ACK2: begin
            event_out = '{scl: 1'b0, sda: 1'b1, sda_drv: 1'b0, bus: 1'b1,
                          nack: 1'b0, last: !stop_ff, push: 1'b1,
                          code: {4'd0, ack_ff, 1'b0}};
         end
         SEQ_STOP0: begin
            event_out = '{scl: 1'b0, sda: 1'b0, sda_drv: 1'b1, bus: 1'b1,
                          nack: ack_ff, last: 1'b0, push: 1'b0, code: TRC_NONE};
         end
         SEQ_STOP1: begin
            event_out = '{scl: 1'b1, sda: 1'b0, sda_drv: 1'b1, bus: 1'b1,
                          nack: ack_ff, last: 1'b0, push: 1'b1, code: TRC_SCL};
         end
         SEQ_STOP2: begin
            event_out = '{scl: 1'b1, sda: 1'b1, sda_drv: 1'b1, bus: 1'b1,
                          nack: ack_ff, last: 1'b0, push: 1'b1, code: TRC_BOTH};
         end
         SEQ_STOP3: begin
            event_out = '{scl: 1'b1, sda: 1'b1, sda_drv: 1'b0, bus: 1'b0,
                          nack: ack_ff, last: 1'b1, push: 1'b0, code: TRC_NONE};
         end
         default: event_out = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SEQ_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      bit_cnt_ff <= bit_cnt_in;
      shift_ff   <= shift_in;
      ack_ff     <= ack_in;
      stop_ff    <= stop_in;
   end

`include "i2c_master_write_with_trace_macros.svh"

   `I2CMW_ASSERT_IMP(a_start_when_idle, start, phase_ff == SEQ_IDLE, "Sequencer restarted mid-byte")
   `I2CMW_ASSERT_IMP(a_advance_when_busy, advance, phase_ff != SEQ_IDLE, "Sequencer advanced while idle")
   `I2CMW_ASSERT_NEXT(a_ack_follows_bits, advance && phase_ff == SEQ_BIT_C && bit_cnt_ff == BIT_LAST, phase_ff == SEQ_ACK0, "Acknowledge slot not reached after eighth bit")

endmodule

`default_nettype wire

FILE: design/i2c_master_write_with_trace.sv
// ----------------------------------------------------------------------------
// I2C master write engine with line trace
// Top level: request decoding, trace ring pointers and the response register.
// ----------------------------------------------------------------------------
// One request is handled at a time. A trace read that finds entries spends the
// read state on the registered read of the trace memory; a rejected read or one
// that finds the store empty is answered from the idle state. A byte write
// starts the sequencer and then gives one response per bus event, 27 to 33
// events, and every event may also write one trace entry through the single
// write port of the trace memory. Responses pass through an output register
// and a second holding register, so a request is taken while one response
// waits at the output; any step stalls only while both hold a response. The
// trace memory is not cleared at reset; only entries written since reset are
// ever returned.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_write_with_trace (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_kind,
   input  wire logic [i2cmw_pkg::TRACE_W-1:0] req_pin_sample,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_first_byte,
   input  wire logic                          req_last_byte,
   input  wire logic                          req_ack_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_result_type,
   output logic                               rsp_scl_level,
   output logic                               rsp_sda_level,
   output logic                               rsp_sda_driven,
   output logic                               rsp_bus_driven,
   output logic [i2cmw_pkg::TRACE_W-1:0]      rsp_trace_value,
   output logic                               rsp_trace_valid,
   output logic                               rsp_nack_seen,
   output logic                               rsp_last
);

   import i2cmw_pkg::*;

   top_state_type        state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [TRACE_AW-1:0]  wr_idx_ff, wr_idx_in;
   logic [TRACE_AW-1:0]  rd_idx_ff, rd_idx_in;
   logic [TRACE_W-1:0]   prev_ff, prev_in;
   logic                 aborted_ff, aborted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_type              skid_ff;

   logic                 accept;
   logic                 out_free;
   logic                 out_open;
   logic                 out_load;
   logic                 skid_load;
   logic                 empty;
   logic                 rsp_load;
   logic                 push_en;
   logic [TRACE_W-1:0]   push_code;
   logic                 ram_rd_en;
   logic [TRACE_W-1:0]   ram_rd_data;
   logic                 seq_start;
   logic                 seq_adv;
   seq_start_type        seq_info;
   seq_event_type        seq_ev;

   assign out_free  = !skid_valid_ff;
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign empty     = (rd_idx_ff == wr_idx_ff);

   assign seq_info = '{data:  req_data_byte,
                       first: req_first_byte,
                       stop:  req_last_byte || req_ack_level,
                       ack:   req_ack_level};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_READ && mode_ff == MODE_READ && !empty) begin
               state_in = ST_READ;
            end else if (accept && req_kind == KIND_WRITE && mode_ff == MODE_WRITE
                         && (req_first_byte || !aborted_ff)) begin
               state_in = ST_WRITE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            if (out_free && seq_ev.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_load   = 1'b0;
      rsp_in     = '0;
      push_en    = 1'b0;
      push_code  = TRC_NONE;
      ram_rd_en  = 1'b0;
      seq_start  = 1'b0;
      seq_adv    = 1'b0;
      rd_idx_in  = rd_idx_ff;
      prev_in    = prev_ff;
      aborted_in = aborted_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_SAMPLE: begin
                     if (req_pin_sample != prev_ff) begin
                        push_en   = 1'b1;
                        push_code = req_pin_sample;
                        prev_in   = req_pin_sample;
                     end
                  end
                  KIND_READ: begin
                     if (mode_ff != MODE_READ) begin
                        rsp_load           = 1'b1;
                        rsp_in.result_type = RES_REJECT;
                        rsp_in.last        = 1'b1;
                     end else if (empty) begin
                        rsp_load           = 1'b1;
                        rsp_in.result_type = RES_TRACE;
                        rsp_in.last        = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                     end
                  end
                  KIND_WRITE: begin
                     if (mode_ff != MODE_WRITE) begin
                        rsp_load           = 1'b1;
                        rsp_in.result_type = RES_REJECT;
                        rsp_in.last        = 1'b1;
                     end else if (req_first_byte || !aborted_ff) begin
                        seq_start  = 1'b1;
                        aborted_in = req_ack_level;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_in.result_type = RES_TRACE;
               rsp_in.trace_value = ram_rd_data;
               rsp_in.trace_valid = 1'b1;
               rsp_in.last        = 1'b1;
               rd_idx_in          = rd_idx_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_in.result_type = RES_BUS;
               rsp_in.scl_level   = seq_ev.scl;
               rsp_in.sda_level   = seq_ev.sda;
               rsp_in.sda_driven  = seq_ev.sda_drv;
               rsp_in.bus_driven  = seq_ev.bus;
               rsp_in.nack_seen   = seq_ev.nack;
               rsp_in.last        = seq_ev.last;
               push_en            = seq_ev.push;
               push_code          = seq_ev.code;
               seq_adv            = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_idx_in     = push_en ? wr_idx_ff + 1'b1 : wr_idx_ff;
   assign mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
   assign out_load      = out_open && (skid_valid_ff || rsp_load);
   assign skid_load     = !out_open && rsp_load;
   assign rsp_valid_in  = out_open ? (skid_valid_ff || rsp_load) : 1'b1;
   assign skid_valid_in = skid_valid_ff ? !out_open : skid_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= '0;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         prev_ff       <= '0;
         aborted_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         prev_ff       <= prev_in;
         aborted_ff    <= aborted_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      if (out_load) begin
         rsp_ff <= skid_valid_ff ? skid_ff : rsp_in;
      end
      if (skid_load) begin
         skid_ff <= rsp_in;
      end
   end

   i2cmw_trace_ram #(
      .DEPTH (TRACE_DEPTH),
      .WIDTH (TRACE_W)
   ) u_trace_ram (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (wr_idx_ff),
      .wr_data (push_code),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   i2cmw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (seq_start),
      .start_info (seq_info),
      .advance    (seq_adv),
      .event_out  (seq_ev)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_type = rsp_ff.result_type;
   assign rsp_scl_level   = rsp_ff.scl_level;
   assign rsp_sda_level   = rsp_ff.sda_level;
   assign rsp_sda_driven  = rsp_ff.sda_driven;
   assign rsp_bus_driven  = rsp_ff.bus_driven;
   assign rsp_trace_value = rsp_ff.trace_value;
   assign rsp_trace_valid = rsp_ff.trace_valid;
   assign rsp_nack_seen   = rsp_ff.nack_seen;
   assign rsp_last        = rsp_ff.last;

`include "i2c_master_write_with_trace_macros.svh"

   `I2CMW_ASSERT_IMP(a_pop_not_empty, state_ff == ST_READ, !empty, "Trace pop from an empty store")
   `I2CMW_ASSERT_IMP(a_no_push_on_read, state_ff == ST_READ, !push_en, "Trace write during a pop")
   `I2CMW_ASSERT_NEXT(a_pop_path, accept && req_kind == KIND_READ && mode_ff == MODE_READ && !empty, state_ff == ST_READ, "Non-empty pop did not enter the read state")

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master write engine with line trace: testbench
// Drives pin samples, trace reads and byte writes through every transfer mode,
// first from a short directed table and then in random phases, and checks each
// response field by field against typed-in results or a predictor of the bus
// events and the trace ring, with random gaps on the request side and random
// stalls on the response side.
// ----------------------------------------------------------------------------

module testbench;
   import i2cmw_pkg::*;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_NONE   = 2'd3;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 50;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_REQUESTS = 32;

   typedef struct {
      logic [1:0]         kind;
      logic [TRACE_W-1:0] pins;
      logic [7:0]         data;
      logic               first;
      logic               stop;
      logic               ack;
   } i2c_request_type;

   typedef struct {
      logic [1:0]         mode;
      i2c_request_type    req;
      bit                 fixed;
      logic [1:0]         res_type;
      logic [TRACE_W-1:0] value;
      logic               valid;
   } stimulus_row_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_wr_en      = 1'b0;
   logic [1:0]         csr_wr_data    = 2'd0;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind       = KIND_SAMPLE;
   logic [TRACE_W-1:0] req_pin_sample = '0;
   logic [7:0]         req_data_byte  = 8'd0;
   logic               req_first_byte = 1'b0;
   logic               req_last_byte  = 1'b0;
   logic               req_ack_level  = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [1:0]         rsp_result_type;
   logic               rsp_scl_level;
   logic               rsp_sda_level;
   logic               rsp_sda_driven;
   logic               rsp_bus_driven;
   logic [TRACE_W-1:0] rsp_trace_value;
   logic               rsp_trace_valid;
   logic               rsp_nack_seen;
   logic               rsp_last;

   logic [TRACE_W-1:0]  trace_mem [TRACE_DEPTH];
   logic [TRACE_AW-1:0] trace_wr  = '0;
   logic [TRACE_AW-1:0] trace_rd  = '0;
   logic [TRACE_W-1:0]  last_pins = '0;
   bit                  aborted   = 1'b0;
   logic [1:0]          mode_reg  = MODE_IDLE;

   rsp_type          expected_q[$];
   rsp_type          event_q[$];
   stimulus_row_type directed[$];
   int               mismatches    = 0;
   int               cycles        = 0;
   int               send_idle_pct = 0;
   int               stall_pct     = 0;

   i2c_master_write_with_trace DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_pin_sample  (req_pin_sample),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .req_ack_level   (req_ack_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_type (rsp_result_type),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_sda_driven  (rsp_sda_driven),
      .rsp_bus_driven  (rsp_bus_driven),
      .rsp_trace_value (rsp_trace_value),
      .rsp_trace_valid (rsp_trace_valid),
      .rsp_nack_seen   (rsp_nack_seen),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic rsp_type bus_event(logic scl, sda, drv, bus, nack);
      rsp_type r;
      r            = '0;
      r.result_type = RES_BUS;
      r.scl_level  = scl;
      r.sda_level  = sda;
      r.sda_driven = drv;
      r.bus_driven = bus;
      r.nack_seen  = nack;
      return r;
   endfunction

   function automatic rsp_type answer(logic [1:0] res_type, logic [TRACE_W-1:0] value,
                                      logic valid);
      rsp_type r;
      r             = '0;
      r.result_type = res_type;
      r.trace_value = value;
      r.trace_valid = valid;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic i2c_request_type random_request();
      i2c_request_type r;
      r.kind  = 2'($urandom_range(3));
      r.pins  = 6'($urandom_range(63));
      r.data  = 8'($urandom_range(255));
      r.first = 1'($urandom_range(1));
      r.stop  = 1'($urandom_range(1));
      r.ack   = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic log_trace(logic [TRACE_W-1:0] code);
      trace_mem[trace_wr] = code;
      trace_wr            = trace_wr + 1'b1;
   endtask

   task automatic model_byte(i2c_request_type r);
      logic [7:0] shifter;
      logic       bitv;
      int         i;
      shifter = r.data;
      if (r.first) begin
         aborted = 1'b0;
         event_q.push_back(bus_event(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
         event_q.push_back(bus_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
         log_trace(TRC_SCL);
         log_trace(TRC_NONE);
      end
      for (i = 0; i < 8; i++) begin
         bitv    = shifter[7];
         shifter = shifter << 1;
         event_q.push_back(bus_event(1'b0, bitv, 1'b1, 1'b1, 1'b0));
         log_trace(bitv ? TRC_BOTH : TRC_SCL);
         event_q.push_back(bus_event(1'b1, bitv, 1'b1, 1'b1, 1'b0));
         event_q.push_back(bus_event(1'b0, bitv, 1'b1, 1'b1, 1'b0));
         log_trace(TRC_NONE);
      end
      event_q.push_back(bus_event(1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
      log_trace(TRC_SDA);
      event_q.push_back(bus_event(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
      log_trace(r.ack ? TRC_BOTH : TRC_SCL);
      event_q.push_back(bus_event(1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
      log_trace(r.ack ? TRC_SDA : TRC_NONE);
      if (r.ack)
         aborted = 1'b1;
      if (r.ack || r.stop) begin
         event_q.push_back(bus_event(1'b0, 1'b0, 1'b1, 1'b1, r.ack));
         event_q.push_back(bus_event(1'b1, 1'b0, 1'b1, 1'b1, r.ack));
         log_trace(TRC_SCL);
         event_q.push_back(bus_event(1'b1, 1'b1, 1'b1, 1'b1, r.ack));
         log_trace(TRC_BOTH);
         event_q.push_back(bus_event(1'b1, 1'b1, 1'b0, 1'b0, r.ack));
      end
   endtask

   task automatic model_request(i2c_request_type r, output bit effective);
      rsp_type tail;
      event_q.delete();
      effective = 1'b0;
      case (r.kind)
         KIND_SAMPLE: begin
            if (r.pins != last_pins) begin
               log_trace(r.pins);
               last_pins = r.pins;
               effective = 1'b1;
            end
         end
         KIND_READ: begin
            if (mode_reg != MODE_READ) begin
               event_q.push_back(answer(RES_REJECT, '0, 1'b0));
            end else if (trace_rd == trace_wr) begin
               event_q.push_back(answer(RES_TRACE, '0, 1'b0));
            end else begin
               event_q.push_back(answer(RES_TRACE, trace_mem[trace_rd], 1'b1));
               trace_rd = trace_rd + 1'b1;
            end
         end
         KIND_WRITE: begin
            if (mode_reg != MODE_WRITE)
               event_q.push_back(answer(RES_REJECT, '0, 1'b0));
            else if (r.first || !aborted)
               model_byte(r);
         end
         default: ;
      endcase
      if (event_q.size() > 0) begin
         tail      = event_q.pop_back();
         tail.last = 1'b1;
         event_q.push_back(tail);
         effective = 1'b1;
      end
   endtask

   task automatic set_mode(logic [1:0] m);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_reg = m;
   endtask

   task automatic send(i2c_request_type r, bit fixed, rsp_type fixed_rsp,
                       output bit effective);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= r.kind;
      req_pin_sample <= r.pins;
      req_data_byte  <= r.data;
      req_first_byte <= r.first;
      req_last_byte  <= r.stop;
      req_ack_level  <= r.ack;
      do
         @(posedge clock);
      while (req_stall);
      model_request(r, effective);
      if (fixed)
         expected_q.push_back(fixed_rsp);
      else
         while (event_q.size() > 0)
            expected_q.push_back(event_q.pop_front());
   endtask

   task automatic add_row(logic [1:0] mode, logic [1:0] kind, logic [TRACE_W-1:0] pins,
                          logic [7:0] data, int first, int stop, int ack, int fixed,
                          logic [1:0] res_type, logic [TRACE_W-1:0] value, int valid);
      stimulus_row_type row;
      row.mode      = mode;
      row.req.kind  = kind;
      row.req.pins  = pins;
      row.req.data  = data;
      row.req.first = 1'(first);
      row.req.stop  = 1'(stop);
      row.req.ack   = 1'(ack);
      row.fixed     = 1'(fixed);
      row.res_type  = res_type;
      row.value     = value;
      row.valid     = 1'(valid);
      directed.push_back(row);
   endtask

   task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_response();
      rsp_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: result_type expected nothing, actual %0h", $time, rsp_result_type);
         mismatches++;
      end else begin
         want = expected_q.pop_front();
         compare_field("result_type", 8'(want.result_type), 8'(rsp_result_type));
         compare_field("scl_level", 8'(want.scl_level), 8'(rsp_scl_level));
         compare_field("sda_level", 8'(want.sda_level), 8'(rsp_sda_level));
         compare_field("sda_driven", 8'(want.sda_driven), 8'(rsp_sda_driven));
         compare_field("bus_driven", 8'(want.bus_driven), 8'(rsp_bus_driven));
         compare_field("trace_value", 8'(want.trace_value), 8'(rsp_trace_value));
         compare_field("trace_valid", 8'(want.trace_valid), 8'(rsp_trace_valid));
         compare_field("nack_seen", 8'(want.nack_seen), 8'(rsp_nack_seen));
         compare_field("last", 8'(want.last), 8'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_response();
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      i2c_request_type r;
      rsp_type         fixed_rsp;
      bit              effective;
      int              counted;
      int              nbytes;
      int              phase;
      int              b;
      logic [1:0]      mode;

      fixed_rsp = '0;

      // Results are typed in only where they follow directly from the reset
      // state, the pin extremes or a rejection.
      add_row(MODE_IDLE,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_REJECT, 6'h00, 0);
      add_row(MODE_IDLE,  KIND_WRITE,  6'h00, 8'hFF, 1, 1, 0, 1, RES_REJECT, 6'h00, 0);
      add_row(MODE_IDLE,  KIND_UNUSED, 6'h3F, 8'hFF, 1, 1, 1, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_IDLE,  KIND_SAMPLE, 6'h00, 8'h00, 0, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_READ,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_TRACE,  6'h00, 0);
      add_row(MODE_READ,  KIND_SAMPLE, 6'h3F, 8'h00, 0, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_READ,  KIND_SAMPLE, 6'h3F, 8'h00, 0, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_READ,  KIND_SAMPLE, 6'h00, 8'h00, 0, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_READ,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_TRACE,  6'h3F, 1);
      add_row(MODE_READ,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_TRACE,  6'h00, 1);
      add_row(MODE_READ,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_TRACE,  6'h00, 0);
      add_row(MODE_READ,  KIND_WRITE,  6'h00, 8'h00, 1, 1, 0, 1, RES_REJECT, 6'h00, 0);
      add_row(MODE_WRITE, KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_REJECT, 6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'hFF, 1, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'h00, 0, 1, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'hA5, 0, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'h5A, 1, 0, 1, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'h33, 0, 1, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'hC3, 1, 1, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'h81, 1, 0, 0, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_WRITE, KIND_WRITE,  6'h00, 8'h7E, 1, 1, 1, 0, RES_BUS,    6'h00, 0);
      add_row(MODE_NONE,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 1, RES_REJECT, 6'h00, 0);
      add_row(MODE_NONE,  KIND_WRITE,  6'h00, 8'h00, 1, 1, 0, 1, RES_REJECT, 6'h00, 0);
      add_row(MODE_READ,  KIND_READ,   6'h00, 8'h00, 0, 0, 0, 0, RES_BUS,    6'h00, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         if (k == 0 || directed[k].mode != mode_reg)
            set_mode(directed[k].mode);
         send(directed[k].req, directed[k].fixed,
              answer(directed[k].res_type, directed[k].value, directed[k].valid), effective);
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            4:       mode = MODE_IDLE;
            7:       mode = MODE_NONE;
            default: mode = phase[0] ? MODE_READ : MODE_WRITE;
         endcase
         set_mode(mode);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         counted = 0;
         while (counted < PHASE_REQUESTS) begin
            if (mode_reg == MODE_WRITE && $urandom_range(99) < 80) begin
               // A well-formed transfer: start on the first byte, stop on the last.
               nbytes = $urandom_range(1, 4);
               for (b = 0; b < nbytes; b++) begin
                  r       = random_request();
                  r.kind  = KIND_WRITE;
                  r.first = (b == 0);
                  r.stop  = (b == nbytes - 1);
                  r.ack   = ($urandom_range(99) < 15);
                  send(r, 1'b0, fixed_rsp, effective);
                  counted += effective;
               end
            end else begin
               r = random_request();
               if (mode_reg == MODE_READ && $urandom_range(99) < 90)
                  r.kind = ($urandom_range(99) < 60) ? KIND_READ : KIND_SAMPLE;
               send(r, 1'b0, fixed_rsp, effective);
               counted += effective;
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
